// ----- rtl/ubds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ubds_pkg;

   localparam int CLK_W     = 28;   // module clock register
   localparam int BAUD_W    = 24;   // requested baud
   localparam int WORD_W    = 29;   // packed baud register word
   localparam int OSR_W     = 5;    // ratio field
   localparam int DIV_BITS  = 12;   // divisor kept from the first quotient
   localparam int DIVF_W    = 12;   // divisor field on the result
   localparam int ERR_W     = 10;   // per mille error on the result

   // shared divider: dividend holds the clock or diff * 1000, divisor holds baud * ratio, divisor * ratio or baud
   localparam int DVD_W     = 38;
   localparam int DSR_W     = 29;
   localparam int CNT_W     = 6;

   localparam int RATIO_SHIFT = 24;
   localparam int EDGE_SHIFT  = 17;

   localparam logic [CLK_W-1:0]  CLK_RESET  = CLK_W'(80000000);
   localparam logic [OSR_W-1:0]  OSR_FIRST  = OSR_W'(3);
   localparam logic [OSR_W-1:0]  OSR_LAST   = OSR_W'(31);
   localparam logic [OSR_W-1:0]  EDGE_LIMIT = OSR_W'(6);
   localparam logic [ERR_W-1:0]  ERR_NONE   = ERR_W'(1000);
   localparam logic [ERR_W-1:0]  ERR_GOOD   = ERR_W'(10);
   localparam logic [ERR_W-1:0]  ERR_SCALE  = ERR_W'(1000);

endpackage
`default_nettype wire

// ----- rtl/uart_baud_divisor_search.sv -----
// Flow: a zero request goes straight to the result; otherwise every ratio tried runs three
// divisions, or one when the divisor comes out zero, until a good match or the last ratio.
// Throughput: one request at a time; the next request beat is taken as soon as the result
// is parked in the output register. One shared bit-serial divider (one quotient bit per
// cycle, three divisions per ratio at most) runs the whole search.
// Reset: synchronous, active high; clears the control state and sets module_clock_hz to 80 MHz.
`timescale 1ns / 1ps
`default_nettype none
module uart_baud_divisor_search
   import ubds_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_write_en,
   input  wire [CLK_W-1:0]     csr_write_data,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire [BAUD_W-1:0]    req_requested_baud,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [WORD_W-1:0]   rsp_baud_word,
   output logic [OSR_W-1:0]    rsp_oversample_ratio,
   output logic [DIVF_W-1:0]   rsp_divisor,
   output logic                rsp_both_edge,
   output logic [ERR_W-1:0]    rsp_error_permille
);

   // sequencer codes
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL1   = 3'd1;  // load divider with clock / (baud * ratio)
   localparam logic [2:0] S_DIV    = 3'd2;  // one quotient bit per cycle
   localparam logic [2:0] S_MUL2   = 3'd3;  // load divider with clock / (divisor * ratio)
   localparam logic [2:0] S_DIFF   = 3'd4;  // |rate - baud|
   localparam logic [2:0] S_MUL3   = 3'd5;  // load divider with diff * 1000 / baud
   localparam logic [2:0] S_NEXT   = 3'd6;  // advance the ratio or stop
   localparam logic [2:0] S_FINISH = 3'd7;  // park the result in the output register

   // which division is running
   localparam logic [1:0] OP_DV   = 2'd0;
   localparam logic [1:0] OP_RATE = 2'd1;
   localparam logic [1:0] OP_ERR  = 2'd2;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [CLK_W-1:0]    clk_ff, clk_in;
   logic [BAUD_W-1:0]   baud_ff, baud_in;
   logic                zero_ff, zero_in;
   logic [OSR_W-1:0]    osr_ff, osr_in;
   logic [DIV_BITS-1:0] dv_ff, dv_in;
   logic [CLK_W-1:0]    val_ff, val_in;     // achieved rate, then its distance to baud
   logic [OSR_W-1:0]    best_osr_ff, best_osr_in;
   logic [DIV_BITS-1:0] best_div_ff, best_div_in;
   logic [ERR_W-1:0]    best_err_ff, best_err_in;

   // divider
   logic [DVD_W-1:0]    dvd_ff, dvd_in;     // dividend shifts out the top, quotient in the bottom
   logic [DSR_W-1:0]    dsr_ff, dsr_in;
   logic [DSR_W-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [OSR_W-1:0]    o_osr_ff, o_osr_in;
   logic [DIVF_W-1:0]   o_div_ff, o_div_in;
   logic                o_edge_ff, o_edge_in;
   logic [ERR_W-1:0]    o_err_ff, o_err_in;

   // datapath helpers
   logic [OSR_W:0]      ratio;
   logic [DSR_W:0]      trial;
   logic                ge;
   logic [DSR_W:0]      trial_sub;
   logic [DVD_W-1:0]    step_dvd;
   logic [DSR_W-1:0]    step_rem;
   logic [DSR_W-1:0]    prod_br;
   logic [DSR_W-1:0]    prod_dr;
   logic [DVD_W-1:0]    prod_err;
   logic                out_free;
   logic                edge_bit;
   logic [DIVF_W-1:0]   best_div_field;

   assign ratio = {1'b0, osr_ff} + (OSR_W+1)'(1);

   // restoring division step
   assign trial     = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge        = trial >= {1'b0, dsr_ff};
   assign trial_sub = trial - {1'b0, dsr_ff};
   assign step_rem  = ge ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
   assign step_dvd  = {dvd_ff[DVD_W-2:0], ge};

   // small products, each registered into the divider before use
   assign prod_br  = DSR_W'(baud_ff) * DSR_W'(ratio);
   assign prod_dr  = DSR_W'(dv_ff) * DSR_W'(ratio);
   assign prod_err = DVD_W'(val_ff) * DVD_W'(ERR_SCALE);

   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign edge_bit       = (best_osr_ff <= EDGE_LIMIT);
   assign best_div_field = DIVF_W'(best_div_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      clk_in       = clk_ff;
      baud_in      = baud_ff;
      zero_in      = zero_ff;
      osr_in       = osr_ff;
      dv_in        = dv_ff;
      val_in       = val_ff;
      best_osr_in  = best_osr_ff;
      best_div_in  = best_div_ff;
      best_err_in  = best_err_ff;
      dvd_in       = dvd_ff;
      dsr_in       = dsr_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      word_in      = word_ff;
      o_osr_in     = o_osr_ff;
      o_div_in     = o_div_ff;
      o_edge_in    = o_edge_ff;
      o_err_in     = o_err_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_en) begin
         clk_in = csr_write_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               baud_in     = req_requested_baud;
               zero_in     = (req_requested_baud == '0);
               osr_in      = OSR_FIRST;
               best_osr_in = '0;
               best_div_in = '0;
               best_err_in = ERR_NONE;
               state_in    = (req_requested_baud == '0) ? S_FINISH : S_MUL1;
            end
         end
         S_MUL1: begin
            // 28-bit dividend sits at the top of the shift register
            dvd_in   = {clk_ff, (DVD_W-CLK_W)'(0)};
            dsr_in   = prod_br;
            rem_in   = '0;
            cnt_in   = CNT_W'(CLK_W);
            op_in    = OP_DV;
            state_in = S_DIV;
         end
         S_DIV: begin
            dvd_in = step_dvd;
            rem_in = step_rem;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               case (op_ff)
                  OP_DV: begin
                     dv_in    = step_dvd[DIV_BITS-1:0];
                     // skip a candidate whose divisor is zero
                     state_in = (step_dvd[DIV_BITS-1:0] == '0) ? S_NEXT : S_MUL2;
                  end
                  OP_RATE: begin
                     val_in   = step_dvd[CLK_W-1:0];
                     state_in = S_DIFF;
                  end
                  default: begin
                     // keep a strictly better candidate, so the earlier ratio wins a tie
                     if (step_dvd < DVD_W'(best_err_ff)) begin
                        best_err_in = step_dvd[ERR_W-1:0];
                        best_osr_in = osr_ff;
                        best_div_in = dv_ff;
                     end
                     state_in = S_NEXT;
                  end
               endcase
            end
         end
         S_MUL2: begin
            dvd_in   = {clk_ff, (DVD_W-CLK_W)'(0)};
            dsr_in   = prod_dr;
            rem_in   = '0;
            cnt_in   = CNT_W'(CLK_W);
            op_in    = OP_RATE;
            state_in = S_DIV;
         end
         S_DIFF: begin
            if (val_ff > CLK_W'(baud_ff)) begin
               val_in = val_ff - CLK_W'(baud_ff);
            end else begin
               val_in = CLK_W'(baud_ff) - val_ff;
            end
            state_in = S_MUL3;
         end
         S_MUL3: begin
            dvd_in   = prod_err;
            dsr_in   = DSR_W'(baud_ff);
            rem_in   = '0;
            cnt_in   = CNT_W'(DVD_W);
            op_in    = OP_ERR;
            state_in = S_DIV;
         end
         S_NEXT: begin
            // stop early on a good enough match, or after the last ratio
            if (best_err_ff < ERR_GOOD || osr_ff == OSR_LAST) begin
               state_in = S_FINISH;
            end else begin
               osr_in   = osr_ff + OSR_W'(1);
               state_in = S_MUL1;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  word_in   = '0;
                  o_osr_in  = '0;
                  o_div_in  = '0;
                  o_edge_in = 1'b0;
               end else begin
                  word_in   = (WORD_W'(best_osr_ff) << RATIO_SHIFT)
                            | (WORD_W'(edge_bit) << EDGE_SHIFT)
                            | WORD_W'(best_div_field);
                  o_osr_in  = best_osr_ff;
                  o_div_in  = best_div_field;
                  o_edge_in = edge_bit;
               end
               o_err_in = best_err_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         clk_ff       <= CLK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clk_ff       <= clk_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      baud_ff     <= baud_in;
      zero_ff     <= zero_in;
      osr_ff      <= osr_in;
      dv_ff       <= dv_in;
      val_ff      <= val_in;
      best_osr_ff <= best_osr_in;
      best_div_ff <= best_div_in;
      best_err_ff <= best_err_in;
      dvd_ff      <= dvd_in;
      dsr_ff      <= dsr_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      word_ff     <= word_in;
      o_osr_ff    <= o_osr_in;
      o_div_ff    <= o_div_in;
      o_edge_ff   <= o_edge_in;
      o_err_ff    <= o_err_in;
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_baud_word        = word_ff;
   assign rsp_oversample_ratio = o_osr_ff;
   assign rsp_divisor          = o_div_ff;
   assign rsp_both_edge        = o_edge_ff;
   assign rsp_error_permille   = o_err_ff;

endmodule
`default_nettype wire

// ----- rtl/ubds_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubds_checker
   import ubds_pkg::*;
(
   input wire                 clock,
   input wire                 reset,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input wire [WORD_W-1:0]    rsp_baud_word,
   input wire [OSR_W-1:0]     rsp_oversample_ratio,
   input wire [DIVF_W-1:0]    rsp_divisor,
   input wire                 rsp_both_edge,
   input wire [ERR_W-1:0]     rsp_error_permille
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_baud_word)
         && $stable(rsp_error_permille))
      else $error("result beat changed while stalled");

   a_word_pack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_baud_word == {rsp_oversample_ratio, 6'd0, rsp_both_edge, 5'd0,
                                      rsp_divisor})
      else $error("baud word does not match its fields");

   a_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_oversample_ratio != '0
         |-> rsp_both_edge == (rsp_oversample_ratio <= EDGE_LIMIT))
      else $error("both-edge flag disagrees with ratio");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_permille <= ERR_NONE)
      else $error("error above 1000 per mille");

   a_none_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divisor == '0 |-> rsp_error_permille == ERR_NONE)
      else $error("zero divisor with a finite error");

endmodule

bind uart_baud_divisor_search ubds_checker u_ubds_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_baud_word        (rsp_baud_word),
   .rsp_oversample_ratio (rsp_oversample_ratio),
   .rsp_divisor          (rsp_divisor),
   .rsp_both_edge        (rsp_both_edge),
   .rsp_error_permille   (rsp_error_permille)
);
`default_nettype wire

// ----- sim/tb_uart_baud_divisor_search.sv -----
`timescale 1ns / 1ps
module tb_uart_baud_divisor_search;
   import ubds_pkg::*;

   localparam int  LIMIT_CYCLES = 3000000;
   localparam int  HOLD_SPAN    = 400;       // long receiver hold-off, in cycles
   localparam int  GAP_MAX      = 12;

   // one predicted result beat
   typedef struct packed {
      logic [WORD_W-1:0] baud_word;
      logic [OSR_W-1:0]  oversample_ratio;
      logic [DIVF_W-1:0] divisor;
      logic              both_edge;
      logic [ERR_W-1:0]  error_permille;
   } baud_setting_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_en = 1'b0;
   logic [CLK_W-1:0]    csr_write_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BAUD_W-1:0]   req_requested_baud = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WORD_W-1:0]   rsp_baud_word;
   logic [OSR_W-1:0]    rsp_oversample_ratio;
   logic [DIVF_W-1:0]   rsp_divisor;
   logic                rsp_both_edge;
   logic [ERR_W-1:0]    rsp_error_permille;

   // testbench copy of the module clock register
   logic [CLK_W-1:0]    module_clock_hz = CLK_RESET;

   logic [BAUD_W-1:0]   baud_requests[$];     // requests not yet offered
   baud_setting_type    expected_settings[$]; // predicted results, oldest first

   logic                req_accepted = 1'b0;  // a request beat happened at the last edge
   logic                rsp_accepted = 1'b0;  // a result beat happened at the last edge
   logic                quiet = 1'b0;         // suppress the random gaps on both sides
   int                  hold_asked = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;
   int                  fail_count = 0;
   int                  cycle_count = 0;

   uart_baud_divisor_search u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_requested_baud   (req_requested_baud),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_baud_word        (rsp_baud_word),
      .rsp_oversample_ratio (rsp_oversample_ratio),
      .rsp_divisor          (rsp_divisor),
      .rsp_both_edge        (rsp_both_edge),
      .rsp_error_permille   (rsp_error_permille)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Search ratio fields 3..31 for the divisor with the smallest rate error.
   // All arithmetic is 64 bits wide, so nothing wraps.
   function automatic baud_setting_type search_baud_setting(input logic [BAUD_W-1:0] baud_in,
                                                            input logic [CLK_W-1:0]  clock_in);
      logic [63:0]      baud;
      logic [63:0]      clk_hz;
      logic [63:0]      ratio;
      logic [63:0]      div_try;
      logic [63:0]      rate;
      logic [63:0]      diff;
      logic [63:0]      err;
      logic [63:0]      best_err;
      logic [63:0]      best_osr;
      logic [63:0]      best_div;
      logic             edge_flag;
      baud_setting_type setting;
      baud     = 64'(baud_in);
      clk_hz   = 64'(clock_in);
      best_err = 64'(ERR_NONE);
      best_osr = '0;
      best_div = '0;
      setting  = '0;
      // a zero request gives all zeros but the error
      if (baud == 64'd0) begin
         setting.error_permille = ERR_NONE;
         return setting;
      end
      for (int osr = int'(OSR_FIRST); osr <= int'(OSR_LAST); osr++) begin
         ratio   = 64'(osr) + 64'd1;
         div_try = (clk_hz / (baud * ratio)) & ((64'd1 << DIV_BITS) - 64'd1);
         // skip a candidate whose masked divisor is zero
         if (div_try != 64'd0) begin
            rate = clk_hz / (div_try * ratio);
            diff = (rate > baud) ? (rate - baud) : (baud - rate);
            err  = (diff * 64'(ERR_SCALE)) / baud;
            // keep only a strictly better candidate
            if (err < best_err) begin
               best_err = err;
               best_osr = 64'(osr);
               best_div = div_try;
            end
         end
         // stop early once the error is good enough
         if (best_err < 64'(ERR_GOOD))
            break;
      end
      edge_flag = (best_osr <= 64'(EDGE_LIMIT));
      setting.oversample_ratio = best_osr[OSR_W-1:0];
      setting.divisor          = best_div[DIVF_W-1:0];
      setting.both_edge        = edge_flag;
      setting.error_permille   = best_err[ERR_W-1:0];
      setting.baud_word        = WORD_W'((best_osr << RATIO_SHIFT)
                                         | (64'(edge_flag) << EDGE_SHIFT)
                                         | 64'(best_div[DIVF_W-1:0]));
      return setting;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Monitor: sample both channels at the rising edge, predict on every request
   // beat and compare every result beat with the oldest prediction.
   always @(posedge clock) begin
      baud_setting_type want;
      if (reset) begin
         req_accepted <= 1'b0;
         rsp_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && req_ready;
         rsp_accepted <= rsp_valid && rsp_ready;
         if (req_valid && req_ready)
            expected_settings.push_back(search_baud_setting(req_requested_baud,
                                                            module_clock_hz));
         if (rsp_valid && rsp_ready) begin
            if (expected_settings.size() == 0) begin
               $error("result beat with no request outstanding");
               fail_count++;
            end else begin
               want = expected_settings.pop_front();
               check_field("baud_word", want.baud_word, rsp_baud_word);
               check_field("oversample_ratio", want.oversample_ratio, rsp_oversample_ratio);
               check_field("divisor", want.divisor, rsp_divisor);
               check_field("both_edge", want.both_edge, rsp_both_edge);
               check_field("error_permille", want.error_permille, rsp_error_permille);
            end
         end
      end
   end

   // Driver: offer queued requests at the falling edge, with a random gap
   // after each one. Hold valid and payload until the beat is taken.
   always @(negedge clock) begin
      logic next_valid;
      int   gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_accepted)
            next_valid = 1'b0;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (baud_requests.size() != 0) begin
               req_requested_baud <= baud_requests.pop_front();
               next_valid = 1'b1;
               gap_left = quiet ? 0 : $urandom_range(0, GAP_MAX);
            end
         end
         req_valid <= next_valid;
      end
   end

   // Long hold-off: count it down in its own process, started on request.
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_served != hold_asked) begin
         hold_left <= HOLD_SPAN;
         hold_served <= hold_asked;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: draw a wait for every new result, then raise ready.
   always @(negedge clock) begin
      int   wait_left;
      logic drawn;
      if (reset) begin
         rsp_ready <= 1'b0;
         wait_left = 0;
         drawn = 1'b0;
      end else begin
         if (rsp_accepted)
            drawn = 1'b0;
         if (rsp_valid && !drawn) begin
            wait_left = quiet ? 0 : $urandom_range(0, GAP_MAX);
            drawn = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Write the module clock register; only call this while the block is idle.
   task automatic write_module_clock(input logic [CLK_W-1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      module_clock_hz = value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Wait until every request is offered, taken and answered; sample at the
   // rising edge, where the driver changes nothing.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (baud_requests.size() != 0 || req_valid || expected_settings.size() != 0);
   endtask

   // Mostly log-uniform rates, some standard ones, the odd zero request.
   function automatic logic [BAUD_W-1:0] random_baud();
      logic [BAUD_W-1:0] standard_rates[8];
      int                width;
      int                pick;
      logic [31:0]       value;
      standard_rates = '{24'd300, 24'd9600, 24'd19200, 24'd57600,
                         24'd115200, 24'd460800, 24'd921600, 24'd3000000};
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return '0;
      if (pick <= 6)
         return standard_rates[$urandom_range(0, 7)];
      width = $urandom_range(1, BAUD_W);
      value = ($urandom & ((32'd1 << width) - 32'd1)) | (32'd1 << (width - 1));
      return value[BAUD_W-1:0];
   endfunction

   function automatic logic [CLK_W-1:0] random_clock();
      case ($urandom_range(0, 4))
         0: return CLK_RESET;
         1: return CLK_W'(24000000);
         2: return CLK_W'(48000000);
         3: return CLK_W'($urandom_range(1, 2000));
         default: return CLK_W'($urandom);
      endcase
   endfunction

   initial begin
      // hold reset, then release it at a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset clock value: extremes of the request and common rates
      baud_requests = '{24'd0, 24'hFFFFFF, 24'd1, 24'd9600, 24'd115200,
                        24'd921600, 24'd3000000, 24'd5000000};
      wait_drained();

      // smallest clock: nothing fits, every candidate is skipped
      write_module_clock(CLK_W'(1));
      baud_requests = '{24'd1, 24'd0, 24'hFFFFFF, 24'd2};
      wait_drained();

      // largest clock: divisor overflows the field for slow rates
      write_module_clock({CLK_W{1'b1}});
      baud_requests = '{24'd1, 24'hFFFFFF, 24'd65536, 24'd115200, 24'd8000000};
      wait_drained();

      // random phases; run one of them without idling
      for (int phase = 0; phase < 5; phase++) begin
         write_module_clock(random_clock());
         quiet = (phase == 2);
         for (int n = 0; n < 40; n++)
            baud_requests.push_back(random_baud());
         wait_drained();
      end
      quiet = 1'b0;

      // back-pressure: hold the receiver off while fast requests keep coming,
      // so the result register fills and the input stalls
      write_module_clock(CLK_RESET);
      quiet = 1'b1;
      for (int n = 0; n < 12; n++)
         baud_requests.push_back((n % 3 == 0) ? 24'd8000000 : 24'd0);
      hold_asked++;
      wait_drained();
      quiet = 1'b0;

      // drain the tail of the pipeline
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
